// ----- hdl/lbp_pkg.sv -----
// Shared types and constants for the LED blink pattern generator.
package lbp_pkg;

    // Mode codes held in the three-bit fields of the mode register.
    // Codes 6 and 7 hold the LED as it is.
    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_ONESHOT   = 3'd1,
        MODE_HEARTBEAT = 3'd2,
        MODE_TIMER     = 3'd3,
        MODE_ON        = 3'd4,
        MODE_OFF       = 3'd5
    } t_mode;

    localparam int MODE_BITS  = 3;
    localparam int CFG_BITS   = 12;
    localparam int CFG_LEDS   = CFG_BITS / MODE_BITS;
    localparam int MASK_BITS  = 4;
    localparam int TICK_BITS  = 8;

    typedef logic [TICK_BITS-1:0] t_tick;

    localparam t_tick TIMER_PERIOD      = 8'd10;
    localparam t_tick ONESHOT_ON_TICK   = 8'd4;
    localparam t_tick ONESHOT_OFF_TICK  = 8'd14;
    localparam t_tick HEART_TOGGLE_LAST = 8'd8;
    localparam t_tick HEART_PERIOD      = 8'd22;

endpackage

// ----- hdl/lbp_led_cell.sv -----
// Per-LED pattern state: tick counter, lit bit and oneshot done flag.
module lbp_led_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_advance,
    input  lbp_pkg::t_mode i_mode,
    output logic           o_lit_next
);

    lbp_pkg::t_tick r_tick;
    lbp_pkg::t_tick n_tick;
    logic           r_lit;
    logic           n_lit;
    logic           r_done;
    logic           n_done;
    lbp_pkg::t_tick tick_inc;
    logic           heart_lit;

    assign tick_inc  = r_tick + 8'd1;
    assign heart_lit = (r_tick == '0) ? 1'b0 : r_lit;

    always_comb begin
        n_tick = r_tick;
        n_lit  = r_lit;
        n_done = r_done;
        if (i_advance) begin
            unique case (i_mode)
                lbp_pkg::MODE_NONE, lbp_pkg::MODE_OFF: begin
                    n_lit = 1'b0;
                end
                lbp_pkg::MODE_ON: begin
                    n_lit = 1'b1;
                end
                lbp_pkg::MODE_TIMER: begin
                    if (tick_inc >= lbp_pkg::TIMER_PERIOD) begin
                        n_tick = '0;
                        n_lit  = ~r_lit;
                    end else begin
                        n_tick = tick_inc;
                    end
                end
                lbp_pkg::MODE_ONESHOT: begin
                    n_tick = tick_inc;
                    if (!r_done) begin
                        // A pulse left over from before only goes dark early on.
                        if (r_lit && (tick_inc < lbp_pkg::ONESHOT_ON_TICK)) begin
                            n_lit = 1'b0;
                        end else if (tick_inc == lbp_pkg::ONESHOT_ON_TICK) begin
                            n_lit = 1'b1;
                        end else if (tick_inc == lbp_pkg::ONESHOT_OFF_TICK) begin
                            n_tick = '0;
                            n_lit  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                end
                lbp_pkg::MODE_HEARTBEAT: begin
                    n_tick = tick_inc;
                    n_lit  = heart_lit;
                    if (!tick_inc[0] && (tick_inc <= lbp_pkg::HEART_TOGGLE_LAST)) begin
                        n_lit = ~heart_lit;
                    end else if (tick_inc == lbp_pkg::HEART_PERIOD) begin
                        n_tick = '0;
                    end
                end
                default: begin
                    // Hold codes leave everything as it is.
                end
            endcase
        end
    end

    assign o_lit_next = n_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_lit  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_step) begin
            r_tick <= n_tick;
            r_lit  <= n_lit;
            r_done <= n_done;
        end
    end

endmodule

// ----- hdl/led_blink_pattern_generator.sv -----
// Top level of the LED blink pattern generator: handshake stages, mode register, LED cells.
//
// Usage. Each input word carries one bit, advance. A word with advance set is one
// 50 ms tick: every LED steps its pattern by its three-bit mode field in the mode
// register. Every input word, advancing or not, yields exactly one output word with
// the lit mask of LEDs 0 to 3 after that word's step.
//
// Channels. Input: i_in_valid / o_in_ready with i_advance. Output: o_out_valid /
// i_out_ready with o_lit_mask. The mode register is written through i_cfg_we and
// i_cfg_data; the user must write it only while no word is in flight. No check enforces it.
//
// Timing. A word is captured in an input register, then its step is applied and the
// mask lands in the output register once the output stage is free, which sets
// o_out_valid. One word per cycle is sustained while i_out_ready stays high; the
// LED step is combinational between the input and the output register.
//
// Reset. A synchronous low i_rst_n clears the mode register, all tick counters, lit
// bits and oneshot done flags, and empties both stages.
//
// Stalls. While the receiver holds i_out_ready low, the output word stays put and the
// input register still takes one more word; after that o_in_ready drops.
module led_blink_pattern_generator #(
    parameter int NUM_LEDS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_advance,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lbp_pkg::MASK_BITS-1:0] o_lit_mask,
    input  logic                          i_cfg_we,
    input  logic [lbp_pkg::CFG_BITS-1:0]  i_cfg_data
);

    logic [lbp_pkg::CFG_BITS-1:0]  r_modes;
    logic                          r_in_valid;
    logic                          r_advance;
    logic                          r_out_valid;
    logic [lbp_pkg::MASK_BITS-1:0] r_lit_mask;
    logic [lbp_pkg::MASK_BITS-1:0] n_lit_mask;
    logic [NUM_LEDS-1:0]           lit_next;
    logic                          out_free;
    logic                          step;

    // The output stage frees up when empty or when its word leaves this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= '0;
        end else if (i_cfg_we) begin
            r_modes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_advance <= i_advance;
        end
    end

    genvar g_led;
    generate
        for (g_led = 0; g_led < NUM_LEDS; g_led++) begin : g_cells
            lbp_pkg::t_mode led_mode;
            if (g_led < lbp_pkg::CFG_LEDS) begin : g_cfg
                assign led_mode =
                    lbp_pkg::t_mode'(r_modes[lbp_pkg::MODE_BITS*g_led +: lbp_pkg::MODE_BITS]);
            end else begin : g_nocfg
                // LEDs past the register always read as mode none.
                assign led_mode = lbp_pkg::MODE_NONE;
            end
            lbp_led_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_step     (step),
                .i_advance  (r_advance),
                .i_mode     (led_mode),
                .o_lit_next (lit_next[g_led])
            );
        end

        for (g_led = 0; g_led < lbp_pkg::MASK_BITS; g_led++) begin : g_mask
            if (g_led < NUM_LEDS) begin : g_used
                assign n_lit_mask[g_led] = lit_next[g_led];
            end else begin : g_unused
                assign n_lit_mask[g_led] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_lit_mask <= n_lit_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_lit_mask  = r_lit_mask;

endmodule

// ----- hdl/lbp_checker.sv -----
// Port-level checks for the LED blink pattern generator, with the bind that attaches them.
module lbp_checker #(
    parameter int NUM_LEDS = 4
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [lbp_pkg::MASK_BITS-1:0] o_lit_mask
);

    localparam int USED_BITS = (NUM_LEDS < lbp_pkg::MASK_BITS) ? NUM_LEDS : lbp_pkg::MASK_BITS;
    localparam logic [lbp_pkg::MASK_BITS-1:0] UNUSED_MASK =
        ~lbp_pkg::MASK_BITS'((1 << USED_BITS) - 1);

    // The block empties its output stage on reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // Input may only be refused while an output word is stalled.
    a_ready_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input refused without an output stall");

    // LEDs that do not exist never show as lit.
    a_unused_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_lit_mask & UNUSED_MASK) == '0))
        else $error("lit bit set for a missing LED");

    // A stalled output word keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_lit_mask)))
        else $error("stalled output word changed");

endmodule

bind led_blink_pattern_generator lbp_checker #(.NUM_LEDS(NUM_LEDS)) u_lbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_lit_mask  (o_lit_mask)
);
